@@ hdl/audio_effect_chain_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the audio effect chain
// Implication checks clocked on aclk and held off while aresetn is low.
// ---------------------------------------------------------------------------
`ifndef AUDIO_EFFECT_CHAIN_MACROS_SVH
`define AUDIO_EFFECT_CHAIN_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define AEC_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define AEC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/aec_pkg.sv @@
// ---------------------------------------------------------------------------
// Audio effect chain package
// Default parameters, fixed-point constants, register codes and the noise
// digit helper.
// ---------------------------------------------------------------------------
package aec_pkg;

    localparam int ECHO_DELAY_DEF  = 4800;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int OUT_BITS        = 27;
    localparam int RANDOM_BITS     = 32;

    localparam int TREM_SPAN        = 10000;
    localparam int TREM_DEPTH_Q15   = 26214;
    localparam int TREM_RECIP_SHIFT = 40;
    localparam int TREM_RECIP       = 109951162;
    localparam int UNITY_Q15        = 32768;

    localparam int ECHO_DECAY_Q15 = 27853;
    localparam int DIST_GAIN      = 3;
    localparam int CLIP_LEVEL     = 22000;
    localparam int SMOOTH_NEW_Q15 = 3277;
    localparam int SMOOTH_OLD_Q15 = 29491;

    localparam int NOISE_OFFSET = 5;
    localparam int PCM16_MAX    = 32767;
    localparam int PCM16_MIN    = -32768;

    typedef logic [1:0] cfg_index_t;

    localparam cfg_index_t REG_TREMOLO_EN    = 2'd0;
    localparam cfg_index_t REG_ECHO_EN       = 2'd1;
    localparam cfg_index_t REG_DISTORTION_EN = 2'd2;
    localparam cfg_index_t REG_NOISE_EN      = 2'd3;

    // Remainder of a 32-bit word by ten, built from its parity and its
    // remainder by five (sixteen is one more than a multiple of five).
    function automatic logic [3:0] noise_index(input logic [31:0] word);
        logic [6:0] nib_sum;
        logic [4:0] fold;
        logic [2:0] mod5;
        nib_sum = '0;
        for (int i = 0; i < 8; i++) begin
            nib_sum = nib_sum + 7'(word[4*i +: 4]);
        end
        fold = 5'(nib_sum[6:4]) + 5'(nib_sum[3:0]);
        if (fold >= 5'd20) begin
            mod5 = 3'(fold - 5'd20);
        end else if (fold >= 5'd15) begin
            mod5 = 3'(fold - 5'd15);
        end else if (fold >= 5'd10) begin
            mod5 = 3'(fold - 5'd10);
        end else if (fold >= 5'd5) begin
            mod5 = 3'(fold - 5'd5);
        end else begin
            mod5 = fold[2:0];
        end
        if (mod5[0] == word[0]) begin
            return {1'b0, mod5};
        end else begin
            return {1'b0, mod5} + 4'd5;
        end
    endfunction

endpackage

@@ hdl/audio_effect_chain.sv @@
// ---------------------------------------------------------------------------
// Audio effect chain
// Tremolo, echo, distortion with smoothing, and noise with 16-bit clamping,
// applied in that order to one sample per transaction.
// ---------------------------------------------------------------------------
// A sample transaction is taken only while the sequencer is idle. It then
// steps one shared registered multiplier through the enabled stages, and
// takes no new sample until the last one is done; disabled stages are
// skipped, and distortion takes extra steps when it soft-clips. A result
// waits in the output register while the next sample is taken; only when it
// is still waiting at the end of the following sample does the chain hold.
// The echo line is a RAM of ECHO_DELAY entries with no clearing pass: its taps
// read as zero until the write pointer has wrapped once.
module audio_effect_chain #(
    parameter int ECHO_DELAY  = aec_pkg::ECHO_DELAY_DEF,
    parameter int SAMPLE_BITS = aec_pkg::SAMPLE_BITS_DEF,
    localparam int IN_W  = ((SAMPLE_BITS + aec_pkg::RANDOM_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((aec_pkg::OUT_BITS + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                cfg_we,
    input  aec_pkg::cfg_index_t cfg_index,
    input  logic [0:0]          cfg_wdata,

    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [IN_W-1:0]     s_tdata,   // in_sample, random_word

    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_W-1:0]    m_tdata    // out_sample
);

    `include "audio_effect_chain_macros.svh"

    localparam int XW    = SAMPLE_BITS + 3;
    localparam int MA    = (XW + 1 > 29) ? XW + 1 : 29;
    localparam int MB    = (XW - 1 > 28) ? XW - 1 : 28;
    localparam int P     = MA + MB;
    localparam int PTR_W = (ECHO_DELAY > 1) ? $clog2(ECHO_DELAY) : 1;
    localparam int OB    = aec_pkg::OUT_BITS;

    localparam logic [MB-1:0] DIV5_RECIP = MB'((64'd1 << XW) / 64'd5);
    localparam logic signed [XW-1:0] CLIP_HI = XW'(aec_pkg::CLIP_LEVEL);
    localparam logic signed [XW-1:0] CLIP_LO = XW'(-aec_pkg::CLIP_LEVEL);
    localparam logic signed [XW:0] PCM_HI = (XW + 1)'(aec_pkg::PCM16_MAX);
    localparam logic signed [XW:0] PCM_LO = (XW + 1)'(aec_pkg::PCM16_MIN);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(ECHO_DELAY - 1);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_TREM0 = 5'd1;
    localparam logic [4:0] ST_TREM1 = 5'd2;
    localparam logic [4:0] ST_TREM2 = 5'd3;
    localparam logic [4:0] ST_TREM3 = 5'd4;
    localparam logic [4:0] ST_TREM4 = 5'd5;
    localparam logic [4:0] ST_TREM5 = 5'd6;
    localparam logic [4:0] ST_ECHO0 = 5'd7;
    localparam logic [4:0] ST_ECHO1 = 5'd8;
    localparam logic [4:0] ST_DIST0 = 5'd9;
    localparam logic [4:0] ST_DIST1 = 5'd10;
    localparam logic [4:0] ST_DIST2 = 5'd11;
    localparam logic [4:0] ST_DIST3 = 5'd12;
    localparam logic [4:0] ST_DIST4 = 5'd13;
    localparam logic [4:0] ST_DIST5 = 5'd14;
    localparam logic [4:0] ST_DIST6 = 5'd15;
    localparam logic [4:0] ST_DIST7 = 5'd16;
    localparam logic [4:0] ST_DIST8 = 5'd17;
    localparam logic [4:0] ST_NOISE = 5'd18;
    localparam logic [4:0] ST_OUT   = 5'd19;

    function automatic logic signed [P-1:0] trunc_q15(input logic signed [P-1:0] v);
        logic signed [P-1:0] bias;
        bias = v[P-1] ? P'(aec_pkg::UNITY_Q15 - 1) : '0;
        return (v + bias) >>> 15;
    endfunction

    logic [4:0]              state_reg, state_next;
    logic                    trem_en_reg, trem_en_next;
    logic                    echo_en_reg, echo_en_next;
    logic                    dist_en_reg, dist_en_next;
    logic                    noise_en_reg, noise_en_next;
    logic signed [XW-1:0]    x_reg, x_next;
    logic [3:0]              noise_idx_reg, noise_idx_next;
    logic [13:0]             phase_reg, phase_next;
    logic [PTR_W-1:0]        ptr_reg, ptr_next;
    logic                    line_full_reg, line_full_next;
    logic signed [XW-1:0]    smooth_reg, smooth_next;
    logic signed [P-1:0]     prod_reg, prod_next;
    logic signed [P-1:0]     acc_reg, acc_next;
    logic [27:0]             trem_n_reg, trem_n_next;
    logic [14:0]             trem_q_reg, trem_q_next;
    logic [16:0]             gain_reg, gain_next;
    logic [XW-1:0]           clip_mag_reg, clip_mag_next;
    logic [XW-1:0]           clip_q_reg, clip_q_next;
    logic                    clip_neg_reg, clip_neg_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [OB-1:0]           m_data_reg, m_data_next;

    logic signed [MA-1:0]    mul_a;
    logic signed [MB-1:0]    mul_b;
    logic [SAMPLE_BITS-1:0]  in_sample;
    logic [31:0]             random_word;
    logic [13:0]             phase_inc;
    logic signed [15:0]      trem_diff;
    logic [13:0]             trem_dist;
    logic [28:0]             trem_rem;
    logic [SAMPLE_BITS-1:0]  ram_rdata;
    logic [SAMPLE_BITS-1:0]  echo_tap;
    logic                    ram_we;
    logic signed [P-1:0]     prod_q15;
    logic signed [P-1:0]     smooth_sum;
    logic signed [P-1:0]     smooth_q15;
    logic signed [XW-1:0]    dist_y;
    logic [XW+1:0]           five_q;
    logic [XW+1:0]           clip_rem;
    logic signed [4:0]       noise_off;
    logic signed [XW:0]      noisy;
    logic [XW+OB-1:0]        out_full;
    logic                    out_load;

    assign in_sample   = s_tdata[SAMPLE_BITS-1:0];
    assign random_word = s_tdata[SAMPLE_BITS +: aec_pkg::RANDOM_BITS];

    assign phase_inc = (phase_reg == 14'(aec_pkg::TREM_SPAN - 1)) ? '0 : phase_reg + 14'd1;
    assign trem_diff = $signed({1'b0, phase_inc, 1'b0}) - 16'(aec_pkg::TREM_SPAN);
    assign trem_dist = trem_diff[15] ? 14'(-trem_diff) : trem_diff[13:0];
    assign trem_rem  = {1'b0, trem_n_reg} - prod_reg[28:0];

    assign echo_tap   = line_full_reg ? ram_rdata : '0;
    assign prod_q15   = trunc_q15(prod_reg);
    assign smooth_sum = acc_reg + prod_reg;
    assign smooth_q15 = trunc_q15(smooth_sum);
    assign dist_y     = prod_reg[XW-1:0];
    assign five_q     = {clip_q_reg, 2'b00} + {2'b00, clip_q_reg};
    assign clip_rem   = {2'b00, clip_mag_reg} - five_q;
    assign noise_off  = $signed({1'b0, noise_idx_reg}) - 5'(aec_pkg::NOISE_OFFSET);
    assign noisy      = {x_reg[XW-1], x_reg} + (XW + 1)'(noise_off);
    assign out_full   = {{OB{x_reg[XW-1]}}, x_reg};
    assign out_load   = !m_tvalid_reg || m_tready;
    assign prod_next  = mul_a * mul_b;

    always_comb begin
        state_next     = state_reg;
        trem_en_next   = trem_en_reg;
        echo_en_next   = echo_en_reg;
        dist_en_next   = dist_en_reg;
        noise_en_next  = noise_en_reg;
        x_next         = x_reg;
        noise_idx_next = noise_idx_reg;
        phase_next     = phase_reg;
        ptr_next       = ptr_reg;
        line_full_next = line_full_reg;
        smooth_next    = smooth_reg;
        acc_next       = acc_reg;
        trem_n_next    = trem_n_reg;
        trem_q_next    = trem_q_reg;
        gain_next      = gain_reg;
        clip_mag_next  = clip_mag_reg;
        clip_q_next    = clip_q_reg;
        clip_neg_next  = clip_neg_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_data_next    = m_data_reg;
        mul_a          = '0;
        mul_b          = '0;
        ram_we         = 1'b0;

        if (cfg_we) begin
            case (cfg_index)
                aec_pkg::REG_TREMOLO_EN:    trem_en_next  = cfg_wdata[0];
                aec_pkg::REG_ECHO_EN:       echo_en_next  = cfg_wdata[0];
                aec_pkg::REG_DISTORTION_EN: dist_en_next  = cfg_wdata[0];
                aec_pkg::REG_NOISE_EN:      noise_en_next = cfg_wdata[0];
                default: ;
            endcase
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    x_next         = {{3{in_sample[SAMPLE_BITS-1]}}, in_sample};
                    noise_idx_next = aec_pkg::noise_index(random_word);
                    state_next     = ST_TREM0;
                end
            end
            ST_TREM0: begin
                if (trem_en_reg) begin
                    phase_next = phase_inc;
                    mul_a      = MA'(trem_dist);
                    mul_b      = MB'(aec_pkg::TREM_DEPTH_Q15);
                    state_next = ST_TREM1;
                end else begin
                    state_next = ST_ECHO0;
                end
            end
            ST_TREM1: begin
                trem_n_next = prod_reg[27:0];
                mul_a       = MA'(prod_reg[27:0]);
                mul_b       = MB'(aec_pkg::TREM_RECIP);
                state_next  = ST_TREM2;
            end
            ST_TREM2: begin
                trem_q_next = prod_reg[aec_pkg::TREM_RECIP_SHIFT +: 15];
                mul_a       = MA'(prod_reg[aec_pkg::TREM_RECIP_SHIFT +: 15]);
                mul_b       = MB'(aec_pkg::TREM_SPAN);
                state_next  = ST_TREM3;
            end
            ST_TREM3: begin
                gain_next = 17'(aec_pkg::UNITY_Q15) - 17'(trem_q_reg)
                          - ((trem_rem >= 29'(aec_pkg::TREM_SPAN)) ? 17'd1 : 17'd0);
                state_next = ST_TREM4;
            end
            ST_TREM4: begin
                mul_a      = {{(MA - XW){x_reg[XW-1]}}, x_reg};
                mul_b      = MB'(gain_reg);
                state_next = ST_TREM5;
            end
            ST_TREM5: begin
                x_next     = prod_q15[XW-1:0];
                state_next = ST_ECHO0;
            end
            ST_ECHO0: begin
                if (echo_en_reg) begin
                    mul_a  = {{(MA - SAMPLE_BITS){echo_tap[SAMPLE_BITS-1]}}, echo_tap};
                    mul_b  = MB'(aec_pkg::ECHO_DECAY_Q15);
                    ram_we = 1'b1;
                    if (ptr_reg == PTR_LAST) begin
                        ptr_next       = '0;
                        line_full_next = 1'b1;
                    end else begin
                        ptr_next = ptr_reg + PTR_W'(1);
                    end
                    state_next = ST_ECHO1;
                end else begin
                    state_next = ST_DIST0;
                end
            end
            ST_ECHO1: begin
                x_next     = x_reg + prod_q15[XW-1:0];
                state_next = ST_DIST0;
            end
            ST_DIST0: begin
                if (dist_en_reg) begin
                    mul_a      = {{(MA - XW){x_reg[XW-1]}}, x_reg};
                    mul_b      = MB'(aec_pkg::DIST_GAIN);
                    state_next = ST_DIST1;
                end else begin
                    state_next = ST_NOISE;
                end
            end
            ST_DIST1: begin
                x_next = dist_y;
                if (dist_y > CLIP_HI) begin
                    clip_mag_next = dist_y - CLIP_HI;
                    clip_neg_next = 1'b0;
                    state_next    = ST_DIST2;
                end else if (dist_y < CLIP_LO) begin
                    clip_mag_next = CLIP_LO - dist_y;
                    clip_neg_next = 1'b1;
                    state_next    = ST_DIST2;
                end else begin
                    state_next = ST_DIST6;
                end
            end
            ST_DIST2: begin
                mul_a      = MA'(clip_mag_reg);
                mul_b      = DIV5_RECIP;
                state_next = ST_DIST3;
            end
            ST_DIST3: begin
                clip_q_next = prod_reg[XW +: XW];
                state_next  = ST_DIST4;
            end
            ST_DIST4: begin
                if (clip_rem >= (XW + 2)'(5)) begin
                    clip_q_next = clip_q_reg + XW'(1);
                end
                state_next = ST_DIST5;
            end
            ST_DIST5: begin
                x_next = clip_neg_reg ? CLIP_LO - $signed(clip_q_reg)
                                      : CLIP_HI + $signed(clip_q_reg);
                state_next = ST_DIST6;
            end
            ST_DIST6: begin
                mul_a      = {{(MA - XW){x_reg[XW-1]}}, x_reg};
                mul_b      = MB'(aec_pkg::SMOOTH_NEW_Q15);
                state_next = ST_DIST7;
            end
            ST_DIST7: begin
                acc_next   = prod_reg;
                mul_a      = {{(MA - XW){smooth_reg[XW-1]}}, smooth_reg};
                mul_b      = MB'(aec_pkg::SMOOTH_OLD_Q15);
                state_next = ST_DIST8;
            end
            ST_DIST8: begin
                x_next      = smooth_q15[XW-1:0];
                smooth_next = smooth_q15[XW-1:0];
                state_next  = ST_NOISE;
            end
            ST_NOISE: begin
                if (noise_en_reg) begin
                    if (noisy > PCM_HI) begin
                        x_next = PCM_HI[XW-1:0];
                    end else if (noisy < PCM_LO) begin
                        x_next = PCM_LO[XW-1:0];
                    end else begin
                        x_next = noisy[XW-1:0];
                    end
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_load) begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = out_full[OB-1:0];
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            trem_en_reg   <= 1'b0;
            echo_en_reg   <= 1'b0;
            dist_en_reg   <= 1'b0;
            noise_en_reg  <= 1'b0;
            phase_reg     <= '0;
            ptr_reg       <= '0;
            line_full_reg <= 1'b0;
            smooth_reg    <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            trem_en_reg   <= trem_en_next;
            echo_en_reg   <= echo_en_next;
            dist_en_reg   <= dist_en_next;
            noise_en_reg  <= noise_en_next;
            phase_reg     <= phase_next;
            ptr_reg       <= ptr_next;
            line_full_reg <= line_full_next;
            smooth_reg    <= smooth_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg         <= x_next;
        noise_idx_reg <= noise_idx_next;
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        trem_n_reg    <= trem_n_next;
        trem_q_reg    <= trem_q_next;
        gain_reg      <= gain_next;
        clip_mag_reg  <= clip_mag_next;
        clip_q_reg    <= clip_q_next;
        clip_neg_reg  <= clip_neg_next;
        m_data_reg    <= m_data_next;
    end

    aec_ram #(
        .WIDTH(SAMPLE_BITS),
        .DEPTH(ECHO_DELAY)
    ) u_echo_line (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ptr_reg),
        .wdata(x_reg[SAMPLE_BITS-1:0]),
        .raddr(ptr_reg),
        .rdata(ram_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_W - OB){1'b0}}, m_data_reg};

    `AEC_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "sequencer idle right after an accepted transaction")
    `AEC_ASSERT_NEXT(a_result_loaded, (state_reg == ST_OUT) && out_load, m_tvalid && (state_reg == ST_IDLE), "finished sample was not presented")
    `AEC_ASSERT_NEXT(a_phase_hold, state_reg != ST_TREM0, $stable(phase_reg), "tremolo phase moved outside its step")
    `AEC_ASSERT_NEXT(a_noise_clamp, (state_reg == ST_OUT) && out_load && noise_en_reg, ($signed(m_data_reg) >= -27'sd32768) && ($signed(m_data_reg) <= 27'sd32767), "noise output left the 16-bit range")

endmodule

@@ hdl/aec_ram.sv @@
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module aec_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
